// ===== rtl/parm_pkg.sv =====
`timescale 1ns / 1ps

package parm_pkg;

	localparam int NUM_ITEMS  = 8;
	localparam int ITEM_W     = 3;
	localparam int PAIR_COUNT = (NUM_ITEMS * (NUM_ITEMS - 1)) / 2;
	localparam int PAIR_W     = 5;
	localparam int CNT_W      = 11;
	localparam int THR_W      = 9;
	localparam int PROD_W     = CNT_W + THR_W;
	localparam int MAX_TRANSACTIONS = 1024;
	localparam int CAP_INT    = (MAX_TRANSACTIONS < 2047) ? MAX_TRANSACTIONS : 2047;
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SUPPORT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CONFIDENCE = 2'd1;
	localparam logic [THR_W-1:0] MIN_SUPPORT_RST    = 9'd102;
	localparam logic [THR_W-1:0] MIN_CONFIDENCE_RST = 9'd154;

	// Controller to datapath
	typedef struct packed {
		logic              count_en;
		logic              freq_en;
		logic [ITEM_W-1:0] freq_idx;
		logic              walk_en;
		logic [ITEM_W-1:0] walk_m;
		logic [ITEM_W-1:0] walk_n;
		logic              flush;
	} parm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic can_take;
	} parm_status_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v < COUNT_CAP) ? v + CNT_W'(1) : COUNT_CAP;
	endfunction

	// Slot of the unordered pair {a,b}, a != b
	function automatic logic [PAIR_W-1:0] pair_slot(input logic [ITEM_W-1:0] a,
			input logic [ITEM_W-1:0] b);
		logic [ITEM_W-1:0] lo;
		logic [ITEM_W-1:0] hi;
		logic [7:0]        s;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		s = 8'(lo) * 8'(NUM_ITEMS) - ((8'(lo) * (8'(lo) + 8'd1)) >> 1)
			+ 8'(hi) - 8'(lo) - 8'd1;
		return s[PAIR_W-1:0];
	endfunction

endpackage

// ===== rtl/parm_ctrl.sv =====
`timescale 1ns / 1ps

module parm_ctrl
	import parm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_last,
	output logic         in_ready,
	input  parm_status_t status,
	output parm_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_FREQ  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t              state_q;
	logic [ITEM_W-1:0]   freq_idx_q;
	logic [ITEM_W-1:0]   m_q;
	logic [ITEM_W-1:0]   n_q;

	localparam logic [ITEM_W-1:0] LAST_ITEM = ITEM_W'(NUM_ITEMS - 1);

	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		cmd          = '0;
		cmd.count_en = in_ready && in_valid;
		cmd.freq_en  = (state_q == ST_FREQ);
		cmd.freq_idx = freq_idx_q;
		cmd.walk_en  = (state_q == ST_WALK) && status.can_take;
		cmd.walk_m   = m_q;
		cmd.walk_n   = n_q;
		cmd.flush    = (state_q == ST_FLUSH) && status.can_take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			freq_idx_q <= '0;
			m_q        <= '0;
			n_q        <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					freq_idx_q <= '0;
					if (cmd.count_en && in_last)
						state_q <= ST_FREQ;
				end
				ST_FREQ: begin
					freq_idx_q <= freq_idx_q + ITEM_W'(1);
					if (freq_idx_q == LAST_ITEM) begin
						m_q     <= '0;
						n_q     <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (status.can_take) begin
						n_q <= (n_q == LAST_ITEM) ? '0 : n_q + ITEM_W'(1);
						if (n_q == LAST_ITEM) begin
							m_q <= m_q + ITEM_W'(1);
							if (m_q == LAST_ITEM)
								state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (status.can_take)
						state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_last_leaves_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready)
		else $error("input still taken after final transaction");
`endif

endmodule

// ===== rtl/parm_dp.sv =====
`timescale 1ns / 1ps

module parm_dp
	import parm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data,
	input  logic [7:0]           item_mask,
	input  parm_cmd_t            cmd,
	output parm_status_t         status,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [ITEM_W-1:0]    out_antecedent,
	output logic [ITEM_W-1:0]    out_consequent,
	output logic                 out_holds,
	output logic                 out_rule_valid,
	output logic                 out_last
);

	logic [THR_W-1:0]  min_sup_q;
	logic [THR_W-1:0]  min_conf_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  item_q [NUM_ITEMS];
	logic [CNT_W-1:0]  pair_q [PAIR_COUNT];
	logic [NUM_ITEMS-1:0] freq_q;

	logic              pend_valid_q;
	logic [ITEM_W-1:0] pend_m_q;
	logic [ITEM_W-1:0] pend_n_q;
	logic              pend_holds_q;

	logic [CNT_W-1:0]  mul_a;
	logic [THR_W-1:0]  mul_b;
	logic [CNT_W-1:0]  lhs_cnt;
	logic [PROD_W-1:0] product;
	logic [PROD_W-1:0] lhs;
	logic              ge;
	logic              judged;
	logic              push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sup_q  <= MIN_SUPPORT_RST;
			min_conf_q <= MIN_CONFIDENCE_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_SUPPORT)
				min_sup_q <= cfg_data;
			else if (cfg_index == REG_MIN_CONFIDENCE)
				min_conf_q <= cfg_data;
		end
	end

	// Counters: one transaction updates the total and every counter of its masked items and pairs at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int k = 0; k < NUM_ITEMS; k++)
				item_q[k] <= '0;
			for (int p = 0; p < PAIR_COUNT; p++)
				pair_q[p] <= '0;
		end else if (cmd.flush) begin
			total_q <= '0;
			for (int k = 0; k < NUM_ITEMS; k++)
				item_q[k] <= '0;
			for (int p = 0; p < PAIR_COUNT; p++)
				pair_q[p] <= '0;
		end else if (cmd.count_en) begin
			total_q <= sat_inc(total_q);
			for (int i = 0; i < NUM_ITEMS; i++) begin
				if (item_mask[i])
					item_q[i] <= sat_inc(item_q[i]);
				for (int j = i + 1; j < NUM_ITEMS; j++) begin
					if (item_mask[i] && item_mask[j])
						pair_q[pair_slot(ITEM_W'(i), ITEM_W'(j))] <=
							sat_inc(pair_q[pair_slot(ITEM_W'(i), ITEM_W'(j))]);
				end
			end
		end
	end

	// One shared multiplier: support test while scanning items, confidence test while walking
	always_comb begin
		if (cmd.freq_en) begin
			mul_a   = total_q;
			mul_b   = min_sup_q;
			lhs_cnt = item_q[cmd.freq_idx];
		end else begin
			mul_a   = item_q[cmd.walk_m];
			mul_b   = min_conf_q;
			lhs_cnt = pair_q[pair_slot(cmd.walk_m, cmd.walk_n)];
		end
		product = PROD_W'(mul_a) * PROD_W'(mul_b);
		lhs     = PROD_W'({lhs_cnt, 8'd0});
		ge      = (lhs >= product);
	end

	assign judged = cmd.walk_en && (cmd.walk_m != cmd.walk_n) && freq_q[cmd.walk_m]
		&& freq_q[cmd.walk_n] && (item_q[cmd.walk_m] != '0);

	always_ff @(posedge clk) begin
		if (cmd.freq_en)
			freq_q[cmd.freq_idx] <= ge;
	end

	// Hold one judged rule back so the final one can carry the last mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.flush) begin
			pend_valid_q <= 1'b0;
		end else if (judged) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (judged) begin
			pend_m_q     <= cmd.walk_m;
			pend_n_q     <= cmd.walk_n;
			pend_holds_q <= ge;
		end
	end

	assign push = (judged && pend_valid_q) || cmd.flush;
	assign status.can_take = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (push)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_antecedent <= pend_valid_q ? pend_m_q : '0;
			out_consequent <= pend_valid_q ? pend_n_q : '0;
			out_holds      <= pend_valid_q && pend_holds_q;
			out_rule_valid <= pend_valid_q;
			out_last       <= cmd.flush;
		end
	end

`ifndef SYNTHESIS
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (total_q == '0) && !pend_valid_q)
		else $error("counters not cleared after evaluation");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_rule_valid) |-> out_last)
		else $error("empty result without last mark");
`endif

endmodule

// ===== rtl/pairwise_association_rule_miner.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// s_*      in   tdata[7:0] item_mask, tlast last_transaction
// m_*      out  tdata[2:0] antecedent, [5:3] consequent, [6] rule_holds,
//               [7] rule_valid; tlast last_result
// cfg_*    in   cfg_index 0 min_support_q8, 1 min_confidence_q8; cfg_data[8:0]
//
// Transactions load at one beat per cycle; all item and pair counters update together.
// After the beat with tlast, s_tready drops through the support test of each item, the
// walk over every ordered item pair and a final flush, all paced by the single shared
// multiply-compare unit.
// A stall on m_tready freezes the walk; one result waits in the output register.
// Reset clears all counters and loads the default thresholds.

module pairwise_association_rule_miner
	import parm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,    // [7:0] item_mask
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,    // antecedent, consequent, rule_holds, rule_valid
	output logic                 m_tlast
);

	parm_cmd_t    cmd;
	parm_status_t status;

	logic [ITEM_W-1:0] antecedent;
	logic [ITEM_W-1:0] consequent;
	logic              rule_holds;
	logic              rule_valid;
	logic [7:0]        item_mask;

	// Mask off bits above the item count
	assign item_mask = s_tdata & 8'((1 << NUM_ITEMS) - 1);

	parm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	parm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_mask      (item_mask),
		.cmd            (cmd),
		.status         (status),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_antecedent (antecedent),
		.out_consequent (consequent),
		.out_holds      (rule_holds),
		.out_rule_valid (rule_valid),
		.out_last       (m_tlast)
	);

	// Pack result fields from the lowest bit up
	assign m_tdata = {rule_valid, rule_holds, consequent, antecedent};

`ifndef SYNTHESIS
	a_no_load_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("transaction accepted during evaluation");
`endif

endmodule
